/* rtl/odr_pkg.sv */
package odr_pkg;

   localparam int unsigned MAX_MATRIX_SIDE_DEF = 16;
   localparam int unsigned NUM_CHANNELS = 3;
   localparam int unsigned LEVELS_W = 9;
   localparam int unsigned COORD_W = 16;
   localparam int unsigned PIX_W = 8;
   localparam int unsigned LG_W = 3;
   localparam int unsigned CSR_INDEX_W = 2;

   // lane pipeline: product, clamp, index numerator, index, dividend, then one stage per
   // quotient bit
   localparam int unsigned PRE_STAGES = 5;
   localparam int unsigned DIV_STEPS = PIX_W;
   localparam int unsigned LANE_DEPTH = PRE_STAGES + DIV_STEPS;

   // floor(n / 510) == (n * RECIP_510) >> RECIP_SHIFT for every n below 2**17
   localparam logic [17:0] RECIP_510 = 18'd131587;
   localparam int unsigned RECIP_SHIFT = 26;

   typedef logic [CSR_INDEX_W-1:0] csr_index_type;
   localparam csr_index_type CSR_RED_LEVELS = 2'd0;
   localparam csr_index_type CSR_GREEN_LEVELS = 2'd1;
   localparam csr_index_type CSR_BLUE_LEVELS = 2'd2;

   typedef logic [PIX_W-1:0] pix_type;
   typedef logic [LEVELS_W-1:0] levels_type;

   typedef logic [255:0][7:0] iv_table_type;

   // intensity step 255 div (L-1), indexed by L-1, worked out at elaboration
   function automatic iv_table_type build_iv_table();
      iv_table_type tab;
      int rem;
      int quo;
      for (int d = 0; d < 256; d++) begin
         if (d == 0) begin
            tab[d] = 8'd255;
         end else begin
            rem = 255;
            quo = 0;
            for (int j = 0; j < 256; j++) begin
               if (rem >= d) begin
                  rem = rem - d;
                  quo = quo + 1;
               end
            end
            tab[d] = 8'(quo);
         end
      end
      return tab;
   endfunction

   localparam iv_table_type IV_TABLE = build_iv_table();

   // level count minus one, with out of range counts folded to 2 and 256
   function automatic logic [7:0] levels_m1(input levels_type lv);
      logic [7:0] res;
      if (lv < 9'd2) begin
         res = 8'd1;
      end else if (lv > 9'd256) begin
         res = 8'd255;
      end else begin
         res = 8'(lv - 9'd1);
      end
      return res;
   endfunction

   // log2 of the matrix side, limited by the largest side that fits
   function automatic logic [LG_W-1:0] matrix_lg(input logic [7:0] lm1,
                                                 input logic [LG_W-1:0] max_lg);
      logic [LG_W-1:0] lg;
      if (lm1 <= 8'd2) begin
         lg = 3'd4;
      end else if (lm1 <= 8'd14) begin
         lg = 3'd3;
      end else if (lm1 <= 8'd62) begin
         lg = 3'd2;
      end else begin
         lg = 3'd1;
      end
      if (lg > max_lg) begin
         lg = max_lg;
      end
      return lg;
   endfunction

   // recursive bayer value: the bit pair from coordinate bit 0 ends up most significant
   function automatic logic [7:0] bayer_m(input logic [LG_W-1:0] lg, input logic [3:0] row,
                                          input logic [3:0] col);
      logic [7:0] m;
      m = '0;
      for (int b = 0; b < 4; b++) begin
         if (LG_W'(b) < lg) begin
            m = {m[5:0], row[b] ^ col[b], row[b]};
         end
      end
      return m;
   endfunction

   typedef struct packed {
      pix_type             comp;
      logic [7:0]          lm1;
      logic [LG_W-1:0]     lg;
      logic [7:0]          iv;
      logic signed [9:0]   thr;
   } chan_job_type;

   typedef struct packed {
      chan_job_type [NUM_CHANNELS-1:0] ch;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } front_out_type;

   typedef struct packed {
      pix_type red;
      pix_type green;
      pix_type blue;
   } result_type;

endpackage

/* rtl/odr_front.sv */
module odr_front import odr_pkg::*; #(
   parameter int unsigned MAX_MATRIX_SIDE = MAX_MATRIX_SIDE_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  push,
   output logic                                  full,
   input  logic [COORD_W-1:0]                    pixel_x,
   input  logic [COORD_W-1:0]                    pixel_y,
   input  pix_type [NUM_CHANNELS-1:0]            comp,
   input  levels_type [NUM_CHANNELS-1:0]         levels,
   input  logic                                  take,
   output front_out_type                         front_out
);

   localparam int unsigned MAX_LG = $clog2(MAX_MATRIX_SIDE + 1) - 1;

   job_type     job_in;
   job_type     fq_ff [2];
   logic        fq_wr_ff, fq_wr_in;
   logic        fq_rd_ff, fq_rd_in;
   logic [1:0]  fq_cnt_ff, fq_cnt_in;
   logic        accept;
   logic        release_head;

   // classify: matrix size, threshold offset and intensity step per channel
   always_comb begin
      logic [7:0]      lm1;
      logic [LG_W-1:0] lg;
      logic [7:0]      m;
      for (int c = 0; c < NUM_CHANNELS; c++) begin
         lm1 = levels_m1(levels[c]);
         lg = matrix_lg(lm1, LG_W'(MAX_LG));
         m = bayer_m(lg, pixel_y[3:0], pixel_x[3:0]);
         job_in.ch[c].comp = comp[c];
         job_in.ch[c].lm1 = lm1;
         job_in.ch[c].lg = lg;
         job_in.ch[c].iv = IV_TABLE[lm1];
         job_in.ch[c].thr = signed'({1'b0, m, 1'b0}) - signed'(10'(1) << {lg, 1'b0});
      end
   end

   assign full = (fq_cnt_ff == 2'd2);
   assign accept = push & ~full;
   assign release_head = take & (fq_cnt_ff != 2'd0);

   assign front_out.valid = (fq_cnt_ff != 2'd0);
   assign front_out.job = fq_ff[fq_rd_ff];

   always_comb begin
      fq_wr_in = fq_wr_ff ^ accept;
      fq_rd_in = fq_rd_ff ^ release_head;
      fq_cnt_in = fq_cnt_ff + 2'(accept) - 2'(release_head);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fq_wr_ff <= 1'b0;
         fq_rd_ff <= 1'b0;
         fq_cnt_ff <= 2'd0;
      end else begin
         fq_wr_ff <= fq_wr_in;
         fq_rd_ff <= fq_rd_in;
         fq_cnt_ff <= fq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         fq_ff[fq_wr_ff] <= job_in;
      end
   end

endmodule

/* rtl/odr_lane.sv */
module odr_lane import odr_pkg::*; (
   input  logic         clock,
   input  logic         en,
   input  chan_job_type job,
   output pix_type      result
);

   logic signed [16:0] prod_ff, prod_in;
   pix_type            comp1_ff;
   logic [7:0]         lm1_1_ff;
   logic [LG_W-1:0]    lg1_ff;

   pix_type            val_ff, val_in;
   logic [7:0]         lm1_2_ff;

   logic [16:0]        num_ff, num_in;
   logic [7:0]         lm1_3_ff;

   logic [7:0]         idx_ff, idx_in;
   logic [7:0]         lm1_4_ff;

   logic [16:0]        rem_ff [DIV_STEPS+1];
   logic [16:0]        rem_in [DIV_STEPS+1];
   logic [8:0]         dvs_ff [DIV_STEPS+1];
   logic [8:0]         dvs_in [DIV_STEPS+1];
   pix_type            quo_ff [DIV_STEPS+1];
   pix_type            quo_in [DIV_STEPS+1];

   assign prod_in = 17'(signed'({1'b0, job.iv}) * job.thr);

   // shift by log2(2N) floors the offset; then clamp to the pixel range
   always_comb begin
      logic [3:0]         shamt;
      logic signed [16:0] sum;
      shamt = {lg1_ff, 1'b0} + 4'd1;
      sum = signed'({9'b0, comp1_ff}) + (prod_ff >>> shamt);
      if (sum < 17'sd0) begin
         val_in = '0;
      end else if (sum > 17'sd255) begin
         val_in = 8'd255;
      end else begin
         val_in = sum[7:0];
      end
   end

   always_comb begin
      logic [15:0] vd;
      vd = 16'(val_ff) * 16'(lm1_2_ff);
      num_in = {vd, 1'b0} + 17'd255;
   end

   // nearest level index: divide by 510 through the reciprocal
   always_comb begin
      logic [34:0] recip_prod;
      recip_prod = 35'(num_ff) * 35'(RECIP_510);
      idx_in = recip_prod[RECIP_SHIFT +: 8];
   end

   // level value round(k*255/(L-1)) by restoring division, one quotient bit per stage
   always_comb begin
      logic [16:0] trial;
      rem_in[0] = {idx_ff, 9'b0} - {7'b0, idx_ff, 1'b0} + {9'b0, lm1_4_ff};
      dvs_in[0] = {lm1_4_ff, 1'b0};
      quo_in[0] = '0;
      for (int j = 1; j <= DIV_STEPS; j++) begin
         trial = 17'(dvs_ff[j-1]) << (DIV_STEPS - j);
         dvs_in[j] = dvs_ff[j-1];
         if (rem_ff[j-1] >= trial) begin
            rem_in[j] = rem_ff[j-1] - trial;
            quo_in[j] = quo_ff[j-1] | (PIX_W'(1) << (DIV_STEPS - j));
         end else begin
            rem_in[j] = rem_ff[j-1];
            quo_in[j] = quo_ff[j-1];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prod_ff <= prod_in;
         comp1_ff <= job.comp;
         lm1_1_ff <= job.lm1;
         lg1_ff <= job.lg;
         val_ff <= val_in;
         lm1_2_ff <= lm1_1_ff;
         num_ff <= num_in;
         lm1_3_ff <= lm1_2_ff;
         idx_ff <= idx_in;
         lm1_4_ff <= lm1_3_ff;
         for (int j = 0; j <= DIV_STEPS; j++) begin
            rem_ff[j] <= rem_in[j];
            dvs_ff[j] <= dvs_in[j];
            quo_ff[j] <= quo_in[j];
         end
      end
   end

   assign result = quo_ff[DIV_STEPS];

endmodule

/* rtl/odr_back.sv */
module odr_back import odr_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  front_out_type front_out,
   output logic          take,
   output logic          empty,
   input  logic          pop,
   output result_type    result
);

   pix_type [NUM_CHANNELS-1:0] lane_res;
   logic [LANE_DEPTH-1:0]      valid_ff, valid_in;
   logic                       en;
   logic                       oq_full;
   logic                       oq_push;
   logic                       oq_pop;
   result_type                 oq_ff [2];
   result_type                 oq_data;
   logic                       oq_wr_ff, oq_wr_in;
   logic                       oq_rd_ff, oq_rd_in;
   logic [1:0]                 oq_cnt_ff, oq_cnt_in;

   // whole pipeline moves when the output queue can take its last stage
   assign oq_full = (oq_cnt_ff == 2'd2);
   assign en = ~oq_full | pop;
   assign take = en;

   for (genvar c = 0; c < NUM_CHANNELS; c++) begin : g_lane
      odr_lane u_lane (
         .clock  (clock),
         .en     (en),
         .job    (front_out.job.ch[c]),
         .result (lane_res[c])
      );
   end

   assign valid_in = {valid_ff[LANE_DEPTH-2:0], front_out.valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= valid_in;
      end
   end

   assign oq_push = en & valid_ff[LANE_DEPTH-1];
   assign oq_pop = pop & ~empty;
   assign oq_data.red = lane_res[0];
   assign oq_data.green = lane_res[1];
   assign oq_data.blue = lane_res[2];

   always_comb begin
      oq_wr_in = oq_wr_ff ^ oq_push;
      oq_rd_in = oq_rd_ff ^ oq_pop;
      oq_cnt_in = oq_cnt_ff + 2'(oq_push) - 2'(oq_pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wr_ff <= 1'b0;
         oq_rd_ff <= 1'b0;
         oq_cnt_ff <= 2'd0;
      end else begin
         oq_wr_ff <= oq_wr_in;
         oq_rd_ff <= oq_rd_in;
         oq_cnt_ff <= oq_cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (oq_push) begin
         oq_ff[oq_wr_ff] <= oq_data;
      end
   end

   assign empty = (oq_cnt_ff == 2'd0);
   assign result = oq_ff[oq_rd_ff];

endmodule

/* rtl/ordered_dither_rgb_core.sv */
// a pushed pixel reaches the rsp ports through the input queue, the lane pipeline and the output queue
// throughput: one pixel per cycle while the output queue has room or is popped; the 13-stage lane
// pipeline ends in the 8-stage level divider after the index multiply and advances on that condition
// reset: synchronous, active high; empties both queues and the pipeline, all level counts
// return to 2
module ordered_dither_rgb_core import odr_pkg::*; #(
   parameter int unsigned MAX_MATRIX_SIDE = MAX_MATRIX_SIDE_DEF
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    push,
   output logic                    full,
   input  logic [COORD_W-1:0]      req_pixel_x,
   input  logic [COORD_W-1:0]      req_pixel_y,
   input  logic [PIX_W-1:0]        req_red_in,
   input  logic [PIX_W-1:0]        req_green_in,
   input  logic [PIX_W-1:0]        req_blue_in,
   output logic                    empty,
   input  logic                    pop,
   output logic [PIX_W-1:0]        rsp_red_out,
   output logic [PIX_W-1:0]        rsp_green_out,
   output logic [PIX_W-1:0]        rsp_blue_out,
   input  logic                    csr_we,
   input  csr_index_type           csr_index,
   input  logic [LEVELS_W-1:0]     csr_wdata
);

   levels_type                    red_levels_ff, red_levels_in;
   levels_type                    green_levels_ff, green_levels_in;
   levels_type                    blue_levels_ff, blue_levels_in;
   levels_type [NUM_CHANNELS-1:0] levels;
   pix_type [NUM_CHANNELS-1:0]    comp;
   front_out_type                 front_out;
   logic                          take;
   result_type                    result;

   always_comb begin
      red_levels_in = red_levels_ff;
      green_levels_in = green_levels_ff;
      blue_levels_in = blue_levels_ff;
      if (csr_we) begin
         unique case (csr_index)
            CSR_RED_LEVELS: red_levels_in = csr_wdata;
            CSR_GREEN_LEVELS: green_levels_in = csr_wdata;
            CSR_BLUE_LEVELS: blue_levels_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         red_levels_ff <= 9'd2;
         green_levels_ff <= 9'd2;
         blue_levels_ff <= 9'd2;
      end else begin
         red_levels_ff <= red_levels_in;
         green_levels_ff <= green_levels_in;
         blue_levels_ff <= blue_levels_in;
      end
   end

   assign levels = {blue_levels_ff, green_levels_ff, red_levels_ff};
   assign comp = {req_blue_in, req_green_in, req_red_in};

   odr_front #(
      .MAX_MATRIX_SIDE (MAX_MATRIX_SIDE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .pixel_x   (req_pixel_x),
      .pixel_y   (req_pixel_y),
      .comp      (comp),
      .levels    (levels),
      .take      (take),
      .front_out (front_out)
   );

   odr_back u_back (
      .clock     (clock),
      .reset     (reset),
      .front_out (front_out),
      .take      (take),
      .empty     (empty),
      .pop       (pop),
      .result    (result)
   );

   assign rsp_red_out = result.red;
   assign rsp_green_out = result.green;
   assign rsp_blue_out = result.blue;

endmodule

/* rtl/odr_checker.sv */
module odr_checker import odr_pkg::*; (
   input logic                clock,
   input logic                reset,
   input logic                push,
   input logic                full,
   input logic                empty,
   input logic                pop,
   input logic [PIX_W-1:0]    rsp_red_out,
   input logic [PIX_W-1:0]    rsp_green_out,
   input logic [PIX_W-1:0]    rsp_blue_out
);

   // reset leaves both queues drained
   a_reset_clears: assert property (@(posedge clock) reset |=> (empty && !full))
      else $error("queues not drained by reset");

   // the input queue only fills up through a transfer
   a_full_needs_push: assert property (@(posedge clock) disable iff (reset)
      $rose(full) |-> $past(push))
      else $error("full rose without a push");

   // results only drain through a transfer
   a_empty_needs_pop: assert property (@(posedge clock) disable iff (reset)
      $rose(empty) |-> ($past(pop) || $past(reset)))
      else $error("result lost without a pop");

   a_result_holds: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> ($stable(rsp_red_out) && $stable(rsp_green_out)
                            && $stable(rsp_blue_out)))
      else $error("waiting result changed");

endmodule

bind ordered_dither_rgb_core odr_checker u_checker (.*);
